### src/cxalu_pkg.sv
package cxalu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int KIND_BITS = 3;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS = PROD_BITS + 1;
  localparam int DIV_SHIFT = WORD_BITS - FRAC_BITS;
  localparam int DIV_STEPS = WORD_BITS;
  localparam int CNT_BITS = $clog2(DIV_STEPS);
  localparam int TAG_BITS = 3;

  localparam int IN_DATA_BITS = 2 * WORD_BITS;
  localparam int OUT_DATA_BITS = ((2 * WORD_BITS + 2 + 7) / 8) * 8;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LOAD = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_DIV  = 3'd4,
    KIND_CMP  = 3'd5
  } kind_e;

  // multiplier operand pairs, in issue order
  typedef enum logic [TAG_BITS-1:0] {
    TAG_AR_BR = 3'd0,
    TAG_AI_BI = 3'd1,
    TAG_AI_BR = 3'd2,
    TAG_AR_BI = 3'd3,
    TAG_BR_BR = 3'd4,
    TAG_BI_BI = 3'd5
  } mul_tag_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DRAIN,
    ST_ABS,
    ST_INIT,
    ST_ITER,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic     take;
    logic     mul_en;
    mul_tag_e mul_tag;
    logic     div_abs;
    logic     div_init;
    logic     div_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  div_zero;
    logic  out_free;
  } sts_t;

endpackage

### src/cxalu_ctrl.sv
module cxalu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cxalu_pkg::sts_t   sts_i,
  output cxalu_pkg::cmd_t   cmd_o
);

  cxalu_pkg::state_e state_q, state_d;
  logic [cxalu_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic [cxalu_pkg::CNT_BITS-1:0] mul_last;
  logic needs_mul;

  assign mul_last = (sts_i.kind == cxalu_pkg::KIND_MUL) ?
                    cxalu_pkg::CNT_BITS'(cxalu_pkg::TAG_AR_BI) :
                    cxalu_pkg::CNT_BITS'(cxalu_pkg::TAG_BI_BI);
  assign needs_mul = (sts_i.kind == cxalu_pkg::KIND_MUL) ||
                     ((sts_i.kind == cxalu_pkg::KIND_DIV) && !sts_i.div_zero);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      cxalu_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cxalu_pkg::ST_EXEC;
      end
      cxalu_pkg::ST_EXEC: begin
        if (needs_mul) begin
          state_d = cxalu_pkg::ST_MUL;
          cnt_d   = '0;
        end else begin
          state_d = cxalu_pkg::ST_DONE;
        end
      end
      cxalu_pkg::ST_MUL: begin
        if (cnt_q == mul_last) state_d = cxalu_pkg::ST_DRAIN;
        else cnt_d = cnt_q + 1'b1;
      end
      cxalu_pkg::ST_DRAIN: begin
        state_d = (sts_i.kind == cxalu_pkg::KIND_MUL) ? cxalu_pkg::ST_DONE :
                                                        cxalu_pkg::ST_ABS;
      end
      cxalu_pkg::ST_ABS: begin
        state_d = cxalu_pkg::ST_INIT;
      end
      cxalu_pkg::ST_INIT: begin
        state_d = cxalu_pkg::ST_ITER;
        cnt_d   = '0;
      end
      cxalu_pkg::ST_ITER: begin
        if (cnt_q == cxalu_pkg::CNT_BITS'(cxalu_pkg::DIV_STEPS - 1)) begin
          state_d = cxalu_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cxalu_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = cxalu_pkg::ST_IDLE;
      end
      default: begin
        state_d = cxalu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.mul_tag  = cxalu_pkg::TAG_AR_BR;
    case (state_q)
      cxalu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      cxalu_pkg::ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_tag = cxalu_pkg::mul_tag_e'(cnt_q[cxalu_pkg::TAG_BITS-1:0]);
      end
      cxalu_pkg::ST_ABS: begin
        cmd_o.div_abs = 1'b1;
      end
      cxalu_pkg::ST_INIT: begin
        cmd_o.div_init = 1'b1;
      end
      cxalu_pkg::ST_ITER: begin
        cmd_o.div_step = 1'b1;
      end
      cxalu_pkg::ST_DONE: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cxalu_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_take_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q == cxalu_pkg::ST_EXEC)
    else $error("accepted request did not move to exec");

  a_mul_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cxalu_pkg::ST_MUL |->
      (sts_i.kind == cxalu_pkg::KIND_MUL || sts_i.kind == cxalu_pkg::KIND_DIV))
    else $error("multiplier sequence for a kind that needs none");

  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cxalu_pkg::ST_ITER &&
     cnt_q == cxalu_pkg::CNT_BITS'(cxalu_pkg::DIV_STEPS - 1))
      |=> state_q == cxalu_pkg::ST_DONE)
    else $error("divide iterations did not end");

endmodule

### src/cxalu_datapath.sv
module cxalu_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [cxalu_pkg::KIND_BITS-1:0]       kind_i,
  input  logic signed [cxalu_pkg::WORD_BITS-1:0] op_real_i,
  input  logic signed [cxalu_pkg::WORD_BITS-1:0] op_imag_i,
  input  cxalu_pkg::cmd_t                       cmd_i,
  output cxalu_pkg::sts_t                       sts_o,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [cxalu_pkg::WORD_BITS-1:0]       res_real_o,
  output logic [cxalu_pkg::WORD_BITS-1:0]       res_imag_o,
  output logic                                  divide_ok_o,
  output logic                                  real_greater_o
);

  localparam int W = cxalu_pkg::WORD_BITS;
  localparam int PB = cxalu_pkg::PROD_BITS;
  localparam int SB = cxalu_pkg::SUM_BITS;
  localparam int FB = cxalu_pkg::FRAC_BITS;
  localparam int SH = cxalu_pkg::DIV_SHIFT;
  localparam int SAT_IN = SB - FB;

  function automatic logic [W-1:0] sat_word(input logic [SAT_IN-1:0] v);
    logic [SAT_IN-W:0] top;
    begin
      top = v[SAT_IN-1:W-1];
      if ((&top) || !(|top)) sat_word = v[W-1:0];
      else if (v[SAT_IN-1]) sat_word = cxalu_pkg::WORD_MIN;
      else sat_word = cxalu_pkg::WORD_MAX;
    end
  endfunction

  function automatic logic [W-1:0] div_word(input logic neg, input logic ovf,
                                            input logic [W-1:0] quo);
    begin
      if (!neg) begin
        div_word = (ovf || quo[W-1]) ? cxalu_pkg::WORD_MAX : quo;
      end else begin
        div_word = (ovf || (quo[W-1] && |quo[W-2:0])) ? cxalu_pkg::WORD_MIN :
                                                       (~quo + 1'b1);
      end
    end
  endfunction

  cxalu_pkg::kind_e kind_q;
  logic signed [W-1:0] br_q, bi_q;
  logic signed [W-1:0] acc_re_q, acc_im_q;
  logic div_flag_q;

  logic signed [PB-1:0] prod_q;
  logic                 prod_vld_q;
  cxalu_pkg::mul_tag_e  prod_tag_q;
  logic signed [SB-1:0] sum_re_q, sum_im_q;
  logic [PB-1:0]        den_q;

  logic [PB-1:0] rem_re_q, rem_im_q;
  logic          neg_re_q, neg_im_q;
  logic          ovf_re_q, ovf_im_q;
  logic [W-1:0]  low_re_q, low_im_q;
  logic [W-1:0]  quo_re_q, quo_im_q;

  logic          out_valid_q;
  logic [W-1:0]  res_re_q, res_im_q;
  logic          res_ok_q, res_gt_q;

  // multiplier
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PB-1:0] prod_d;
  logic signed [SB-1:0] prod_ext;

  always_comb begin
    case (cmd_i.mul_tag)
      cxalu_pkg::TAG_AR_BR: begin mul_a = acc_re_q; mul_b = br_q; end
      cxalu_pkg::TAG_AI_BI: begin mul_a = acc_im_q; mul_b = bi_q; end
      cxalu_pkg::TAG_AI_BR: begin mul_a = acc_im_q; mul_b = br_q; end
      cxalu_pkg::TAG_AR_BI: begin mul_a = acc_re_q; mul_b = bi_q; end
      cxalu_pkg::TAG_BR_BR: begin mul_a = br_q; mul_b = br_q; end
      cxalu_pkg::TAG_BI_BI: begin mul_a = bi_q; mul_b = bi_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign prod_ext = {prod_q[PB-1], prod_q};

  // long division lanes
  logic [PB-1:0] mag_re, mag_im;
  logic [SB-1:0] neg_sum_re, neg_sum_im;
  logic [PB:0]   trial_re, trial_im, diff_re, diff_im;
  logic          ge_re, ge_im;

  assign neg_sum_re = ~sum_re_q + 1'b1;
  assign neg_sum_im = ~sum_im_q + 1'b1;
  assign mag_re = sum_re_q[SB-1] ? neg_sum_re[PB-1:0] : sum_re_q[PB-1:0];
  assign mag_im = sum_im_q[SB-1] ? neg_sum_im[PB-1:0] : sum_im_q[PB-1:0];

  assign trial_re = {rem_re_q, low_re_q[W-1]};
  assign trial_im = {rem_im_q, low_im_q[W-1]};
  assign diff_re = trial_re - {1'b0, den_q};
  assign diff_im = trial_im - {1'b0, den_q};
  assign ge_re = !diff_re[PB];
  assign ge_im = !diff_im[PB];

  // writeback values
  logic [W:0]    add_re, add_im, sub_re, sub_im;
  logic [SB-1:0] shr_re, shr_im;
  logic [W-1:0]  new_re, new_im;
  logic          new_flag, new_gt;
  logic          op_zero;

  assign op_zero = (br_q == '0) && (bi_q == '0);
  assign add_re = {acc_re_q[W-1], acc_re_q} + {br_q[W-1], br_q};
  assign add_im = {acc_im_q[W-1], acc_im_q} + {bi_q[W-1], bi_q};
  assign sub_re = {acc_re_q[W-1], acc_re_q} - {br_q[W-1], br_q};
  assign sub_im = {acc_im_q[W-1], acc_im_q} - {bi_q[W-1], bi_q};
  assign shr_re = sum_re_q >>> FB;
  assign shr_im = sum_im_q >>> FB;

  always_comb begin
    new_re   = acc_re_q;
    new_im   = acc_im_q;
    new_flag = div_flag_q;
    new_gt   = 1'b0;
    case (kind_q)
      cxalu_pkg::KIND_LOAD: begin
        new_re = br_q;
        new_im = bi_q;
      end
      cxalu_pkg::KIND_ADD: begin
        new_re = sat_word({{(SAT_IN - W - 1){add_re[W]}}, add_re});
        new_im = sat_word({{(SAT_IN - W - 1){add_im[W]}}, add_im});
      end
      cxalu_pkg::KIND_SUB: begin
        new_re = sat_word({{(SAT_IN - W - 1){sub_re[W]}}, sub_re});
        new_im = sat_word({{(SAT_IN - W - 1){sub_im[W]}}, sub_im});
      end
      cxalu_pkg::KIND_MUL: begin
        new_re = sat_word(shr_re[SAT_IN-1:0]);
        new_im = sat_word(shr_im[SAT_IN-1:0]);
      end
      cxalu_pkg::KIND_DIV: begin
        if (op_zero) begin
          new_flag = 1'b0;
        end else begin
          new_re   = div_word(neg_re_q, ovf_re_q, quo_re_q);
          new_im   = div_word(neg_im_q, ovf_im_q, quo_im_q);
          new_flag = 1'b1;
        end
      end
      cxalu_pkg::KIND_CMP: begin
        new_gt = acc_re_q > br_q;
      end
      default: begin
        new_gt = 1'b0;
      end
    endcase
  end

  // operand and product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= cxalu_pkg::kind_e'(kind_i);
      br_q   <= op_real_i;
      bi_q   <= op_imag_i;
    end
    if (cmd_i.mul_en) prod_q <= prod_d;
    prod_tag_q <= cmd_i.mul_tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  // product sums
  always_ff @(posedge clk_i) begin
    if (prod_vld_q) begin
      case (prod_tag_q)
        cxalu_pkg::TAG_AR_BR: begin
          sum_re_q <= prod_ext;
        end
        cxalu_pkg::TAG_AI_BI: begin
          sum_re_q <= (kind_q == cxalu_pkg::KIND_MUL) ? sum_re_q - prod_ext :
                                                        sum_re_q + prod_ext;
        end
        cxalu_pkg::TAG_AI_BR: begin
          sum_im_q <= prod_ext;
        end
        cxalu_pkg::TAG_AR_BI: begin
          sum_im_q <= (kind_q == cxalu_pkg::KIND_MUL) ? sum_im_q + prod_ext :
                                                        sum_im_q - prod_ext;
        end
        cxalu_pkg::TAG_BR_BR: begin
          den_q <= prod_q;
        end
        cxalu_pkg::TAG_BI_BI: begin
          den_q <= den_q + prod_q;
        end
        default: begin
          den_q <= den_q;
        end
      endcase
    end
  end

  // divider lanes
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_abs) begin
      rem_re_q <= mag_re;
      rem_im_q <= mag_im;
      neg_re_q <= sum_re_q[SB-1];
      neg_im_q <= sum_im_q[SB-1];
    end else if (cmd_i.div_init) begin
      ovf_re_q <= {{SH{1'b0}}, rem_re_q} >= {den_q, {SH{1'b0}}};
      ovf_im_q <= {{SH{1'b0}}, rem_im_q} >= {den_q, {SH{1'b0}}};
      rem_re_q <= rem_re_q >> SH;
      rem_im_q <= rem_im_q >> SH;
      low_re_q <= {rem_re_q[SH-1:0], {FB{1'b0}}};
      low_im_q <= {rem_im_q[SH-1:0], {FB{1'b0}}};
      quo_re_q <= '0;
      quo_im_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_re_q <= ge_re ? diff_re[PB-1:0] : trial_re[PB-1:0];
      rem_im_q <= ge_im ? diff_im[PB-1:0] : trial_im[PB-1:0];
      quo_re_q <= {quo_re_q[W-2:0], ge_re};
      quo_im_q <= {quo_im_q[W-2:0], ge_im};
      low_re_q <= low_re_q << 1;
      low_im_q <= low_im_q << 1;
    end
  end

  // accumulator and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      div_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        acc_re_q    <= new_re;
        acc_im_q    <= new_im;
        div_flag_q  <= new_flag;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_re_q <= new_re;
      res_im_q <= new_im;
      res_ok_q <= new_flag;
      res_gt_q <= new_gt;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.div_zero = op_zero;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign res_real_o     = res_re_q;
  assign res_imag_o     = res_im_q;
  assign divide_ok_o    = res_ok_q;
  assign real_greater_o = res_gt_q;

  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.finish |=> $stable(acc_re_q) && $stable(acc_im_q) && $stable(div_flag_q))
    else $error("accumulator changed outside writeback");

  a_flag_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_flag_q) |-> $past(kind_q) == cxalu_pkg::KIND_DIV)
    else $error("divide flag set by a non-divide request");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("writeback did not present a result");

endmodule

### src/complex_accumulator_alu_core.sv
// channel   dir  tdata fields (lsb first)                          tuser
// s_axis    in   operand_real[31:0], operand_imag[31:0]             kind[2:0]
// m_axis    out  result_real, result_imag, divide_ok, real_greater  -
//
// one request at a time; the next is taken once the previous one is written
// to the output register, even while that result still waits on m_axis
// load, add, subtract, compare: no products, straight from exec to done
// multiply: four products through one 32x32 multiplier
// divide by nonzero: six products then 32 steps of a two-lane restoring divider
// reset clears the accumulator, the divide flag and the output valid
module complex_accumulator_alu_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // operand_real, operand_imag
  input  logic [cxalu_pkg::IN_DATA_BITS-1:0]     s_axis_tdata_i,
  // kind
  input  logic [cxalu_pkg::KIND_BITS-1:0]        s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // result_real, result_imag, divide_ok, real_greater, zero fill
  output logic [cxalu_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata_o
);

  localparam int W = cxalu_pkg::WORD_BITS;

  cxalu_pkg::cmd_t cmd;
  cxalu_pkg::sts_t sts;
  logic [W-1:0] res_real, res_imag;
  logic         divide_ok, real_greater;

  cxalu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cxalu_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (s_axis_tuser_i),
    .op_real_i      (s_axis_tdata_i[W-1:0]),
    .op_imag_i      (s_axis_tdata_i[2*W-1:W]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .res_real_o     (res_real),
    .res_imag_o     (res_imag),
    .divide_ok_o    (divide_ok),
    .real_greater_o (real_greater)
  );

  assign m_axis_tdata_o = {{(cxalu_pkg::OUT_DATA_BITS - 2 * W - 2){1'b0}},
                           real_greater, divide_ok, res_imag, res_real};

endmodule

### tb/tb_complex_accumulator_alu_core.sv
module tb_complex_accumulator_alu_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1030;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;

  localparam logic [cxalu_pkg::KIND_BITS-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [cxalu_pkg::KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

  typedef logic signed [cxalu_pkg::WORD_BITS-1:0] word_t;
  typedef logic signed [2*cxalu_pkg::WORD_BITS+65:0] wide_t;

  typedef struct packed {
    word_t re;
    word_t im;
    logic  div_ok;
    logic  gt;
  } cx_result_t;

  localparam word_t Q_ONE = 32'sh0001_0000;
  localparam wide_t SAT_HI = 2147483647;
  localparam wide_t SAT_LO = -SAT_HI - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [cxalu_pkg::IN_DATA_BITS-1:0] s_data = '0;
  logic [cxalu_pkg::KIND_BITS-1:0] s_user = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [cxalu_pkg::OUT_DATA_BITS-1:0] m_data;

  // predicted accumulator state
  word_t acc_re = '0;
  word_t acc_im = '0;
  logic div_flag = 1'b0;

  cx_result_t expected_acc[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;

  complex_accumulator_alu_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic word_t saturate(input wide_t v);
    if (v > SAT_HI) return cxalu_pkg::WORD_MAX;
    if (v < SAT_LO) return cxalu_pkg::WORD_MIN;
    return v[cxalu_pkg::WORD_BITS-1:0];
  endfunction

  function automatic cx_result_t step_accumulator(
      input logic [cxalu_pkg::KIND_BITS-1:0] kind, input word_t br, input word_t bi);
    word_t ar;
    word_t ai;
    wide_t sum_re;
    wide_t sum_im;
    wide_t den;
    cx_result_t res;
    ar = acc_re;
    ai = acc_im;
    res.gt = 1'b0;
    case (kind)
      cxalu_pkg::KIND_LOAD: begin
        acc_re = br;
        acc_im = bi;
      end
      cxalu_pkg::KIND_ADD: begin
        sum_re = ar + br;
        sum_im = ai + bi;
        acc_re = saturate(sum_re);
        acc_im = saturate(sum_im);
      end
      cxalu_pkg::KIND_SUB: begin
        sum_re = ar - br;
        sum_im = ai - bi;
        acc_re = saturate(sum_re);
        acc_im = saturate(sum_im);
      end
      cxalu_pkg::KIND_MUL: begin
        // floor shift of the exact product sums
        sum_re = (ar * br - ai * bi) >>> cxalu_pkg::FRAC_BITS;
        sum_im = (ai * br + ar * bi) >>> cxalu_pkg::FRAC_BITS;
        acc_re = saturate(sum_re);
        acc_im = saturate(sum_im);
      end
      cxalu_pkg::KIND_DIV: begin
        if (br == 0 && bi == 0) begin
          div_flag = 1'b0;
        end else begin
          den = br * br + bi * bi;
          sum_re = ar * br + ai * bi;
          sum_im = ai * br - ar * bi;
          // signed division truncates toward zero
          sum_re = (sum_re <<< cxalu_pkg::FRAC_BITS) / den;
          sum_im = (sum_im <<< cxalu_pkg::FRAC_BITS) / den;
          acc_re = saturate(sum_re);
          acc_im = saturate(sum_im);
          div_flag = 1'b1;
        end
      end
      cxalu_pkg::KIND_CMP: begin
        res.gt = ar > br;
      end
      default: begin
      end
    endcase
    res.re = acc_re;
    res.im = acc_im;
    res.div_ok = div_flag;
    return res;
  endfunction

  task automatic send_request(input logic [cxalu_pkg::KIND_BITS-1:0] kind,
                              input word_t re, input word_t im);
    while (src_gaps && $urandom_range(99) < 10) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {im, re};
    s_user <= kind;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    expected_acc.push_back(step_accumulator(kind, re, im));
  endtask

  task automatic wait_results_drained();
    while (expected_acc.size() != 0) @(posedge clk);
  endtask

  function automatic word_t rand_operand();
    case ($urandom_range(9))
      0: return '0;
      1: begin
        case ($urandom_range(3))
          0: return cxalu_pkg::WORD_MAX;
          1: return cxalu_pkg::WORD_MIN;
          2: return 1;
          default: return -1;
        endcase
      end
      2, 3: return $urandom;
      default: return word_t'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  task automatic test_load();
    send_request(cxalu_pkg::KIND_LOAD, cxalu_pkg::WORD_MAX, cxalu_pkg::WORD_MIN);
    send_request(cxalu_pkg::KIND_LOAD, cxalu_pkg::WORD_MIN, cxalu_pkg::WORD_MAX);
    send_request(cxalu_pkg::KIND_LOAD, 0, 0);
  endtask

  task automatic test_add_sub();
    send_request(cxalu_pkg::KIND_LOAD, cxalu_pkg::WORD_MAX, cxalu_pkg::WORD_MIN);
    send_request(cxalu_pkg::KIND_ADD, 1, -1);
    send_request(cxalu_pkg::KIND_SUB, -1, 1);
    send_request(cxalu_pkg::KIND_SUB, cxalu_pkg::WORD_MAX, cxalu_pkg::WORD_MIN);
    send_request(cxalu_pkg::KIND_ADD, cxalu_pkg::WORD_MIN, cxalu_pkg::WORD_MAX);
  endtask

  task automatic test_multiply();
    send_request(cxalu_pkg::KIND_LOAD, Q_ONE + Q_ONE / 2, -2 * Q_ONE);
    send_request(cxalu_pkg::KIND_MUL, Q_ONE / 2, 3 * Q_ONE);
    // negative product below one lsb rounds down
    send_request(cxalu_pkg::KIND_LOAD, -1, 0);
    send_request(cxalu_pkg::KIND_MUL, 1, 0);
    send_request(cxalu_pkg::KIND_LOAD, cxalu_pkg::WORD_MIN, cxalu_pkg::WORD_MIN);
    send_request(cxalu_pkg::KIND_MUL, cxalu_pkg::WORD_MIN, cxalu_pkg::WORD_MIN);
  endtask

  task automatic test_divide();
    send_request(cxalu_pkg::KIND_LOAD, 3 * Q_ONE, 4 * Q_ONE);
    send_request(cxalu_pkg::KIND_DIV, Q_ONE, 2 * Q_ONE);
    send_request(cxalu_pkg::KIND_DIV, 0, 0);
    send_request(cxalu_pkg::KIND_DIV, 0, Q_ONE);
    send_request(cxalu_pkg::KIND_DIV, cxalu_pkg::WORD_MIN, cxalu_pkg::WORD_MIN);
  endtask

  task automatic test_compare();
    send_request(cxalu_pkg::KIND_LOAD, 2 * Q_ONE, 0);
    send_request(cxalu_pkg::KIND_CMP, Q_ONE, 0);
    send_request(cxalu_pkg::KIND_CMP, 2 * Q_ONE, 0);
    send_request(cxalu_pkg::KIND_CMP, cxalu_pkg::WORD_MIN, cxalu_pkg::WORD_MAX);
  endtask

  task automatic test_spare_kinds();
    send_request(KIND_SPARE_LO, cxalu_pkg::WORD_MAX, 5);
    send_request(KIND_SPARE_HI, cxalu_pkg::WORD_MIN, -5);
  endtask

  task automatic test_random();
    logic [cxalu_pkg::KIND_BITS-1:0] kind;
    word_t re;
    word_t im;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // stretch with no idling on either side, but for a drain at item 500
      src_gaps = !(i >= 400 && i < 650);
      sink_gaps = src_gaps;
      if (i == 500) begin
        s_valid <= 1'b0;
        wait_results_drained();
      end
      if ($urandom_range(99) < 2) begin
        kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      end else begin
        kind = 3'($urandom_range(int'(cxalu_pkg::KIND_CMP)));
      end
      re = rand_operand();
      im = rand_operand();
      if (kind == cxalu_pkg::KIND_DIV) begin
        case ($urandom_range(19))
          0: begin
            re = '0;
            im = '0;
          end
          1: re = '0;
          2: im = '0;
          default: begin
          end
        endcase
      end else if (kind == cxalu_pkg::KIND_CMP && $urandom_range(4) == 0) begin
        re = acc_re + word_t'($urandom_range(2)) - 1;
      end
      send_request(kind, re, im);
    end
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    cx_result_t want;
    word_t got_re;
    word_t got_im;
    if (m_valid && m_ready) begin
      got_re = m_data[cxalu_pkg::WORD_BITS-1:0];
      got_im = m_data[2*cxalu_pkg::WORD_BITS-1:cxalu_pkg::WORD_BITS];
      if (expected_acc.size() == 0) begin
        $error("result with no request pending: re %0d im %0d", got_re, got_im);
        fail_count++;
      end else begin
        want = expected_acc.pop_front();
        if (got_re !== want.re) begin
          $error("result_real: expected %0d, got %0d", want.re, got_re);
          fail_count++;
        end
        if (got_im !== want.im) begin
          $error("result_imag: expected %0d, got %0d", want.im, got_im);
          fail_count++;
        end
        if (m_data[2*cxalu_pkg::WORD_BITS] !== want.div_ok) begin
          $error("divide_ok: expected %0b, got %0b", want.div_ok,
                 m_data[2*cxalu_pkg::WORD_BITS]);
          fail_count++;
        end
        if (m_data[2*cxalu_pkg::WORD_BITS+1] !== want.gt) begin
          $error("real_greater: expected %0b, got %0b", want.gt,
                 m_data[2*cxalu_pkg::WORD_BITS+1]);
          fail_count++;
        end
      end
    end
    m_ready <= !(sink_gaps && $urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb_complex_accumulator_alu_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load();
    test_add_sub();
    test_multiply();
    test_divide();
    test_compare();
    test_spare_kinds();
    test_random();
    s_valid <= 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_acc.size() == 0) begin
      $display("tb_complex_accumulator_alu_core OK");
    end else begin
      $display("tb_complex_accumulator_alu_core NOT OK");
    end
    $finish;
  end

endmodule

### complex_accumulator_alu_core.f
src/cxalu_pkg.sv
src/cxalu_ctrl.sv
src/cxalu_datapath.sv
src/complex_accumulator_alu_core.sv
tb/tb_complex_accumulator_alu_core.sv
